// ===== rtl/core/bda_pkg.sv =====
`default_nettype none

package bda_pkg;

  // widths fixed by the word fields and the register file
  localparam int unsigned LEVEL_W     = 5;
  localparam int unsigned ELAPSED_W   = 16;
  localparam int unsigned EVENT_W     = 5;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  // buttons carried by the level field
  localparam int unsigned FIELD_BUTTONS = 5;

  // parameter defaults
  localparam int unsigned NUM_BUTTONS_DEF = 5;
  localparam int unsigned TIMER_WIDTH_DEF = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIME  = 1'd1;

  // register reset values
  localparam logic [CFG_W-1:0] SHORT_TIME_RST = 16'd80;
  localparam logic [CFG_W-1:0] LONG_TIME_RST  = 16'd300;

  // per-button debounce state
  typedef enum logic [3:0] {
    MODE_RELEASED       = 4'b0001,
    MODE_PRESS_SETTLE   = 4'b0010,
    MODE_HELD           = 4'b0100,
    MODE_RELEASE_SETTLE = 4'b1000
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/core/bda_button.sv =====
`default_nettype none

module bda_button #(
  parameter int unsigned TIMER_WIDTH = bda_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           pressed,
  input  logic [bda_pkg::ELAPSED_W-1:0]  elapsed,
  input  logic [TIMER_WIDTH-1:0]         short_load,
  input  logic [TIMER_WIDTH-1:0]         long_load,
  output logic                           fire
);
  import bda_pkg::*;

  localparam int unsigned CMP_W = (TIMER_WIDTH > ELAPSED_W) ? TIMER_WIDTH : ELAPSED_W;

  mode_t                  mode_r, mode_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [CMP_W-1:0]       timer_ext;
  logic [CMP_W-1:0]       elapsed_ext;
  logic                   expired;
  logic [TIMER_WIDTH-1:0] remain;

  // expiry compare and countdown
  assign timer_ext   = CMP_W'(timer_r);
  assign elapsed_ext = CMP_W'(elapsed);
  assign expired     = (elapsed_ext >= timer_ext);
  assign remain      = TIMER_WIDTH'(timer_ext - elapsed_ext);

  // mode transitions
  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_r;
    fire      = 1'b0;
    if (step) begin
      case (mode_r)
        MODE_RELEASED: begin
          if (pressed) begin
            mode_nxt  = MODE_PRESS_SETTLE;
            timer_nxt = short_load;
          end
        end
        MODE_PRESS_SETTLE: begin
          if (expired) begin
            fire      = 1'b1;
            mode_nxt  = MODE_HELD;
            timer_nxt = long_load;
          end else begin
            timer_nxt = remain;
          end
        end
        MODE_HELD: begin
          if (!pressed) begin
            mode_nxt  = MODE_RELEASE_SETTLE;
            timer_nxt = short_load;
          end else if (expired) begin
            fire      = 1'b1;
            timer_nxt = long_load;
          end else begin
            timer_nxt = remain;
          end
        end
        MODE_RELEASE_SETTLE: begin
          if (expired) begin
            mode_nxt = MODE_RELEASED;
          end else begin
            timer_nxt = remain;
          end
        end
        default: begin
          mode_nxt = MODE_RELEASED;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RELEASED;
      timer_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
    end
  end

`ifndef SYNTH
  // events only come out of the settling-after-press and held modes
  a_fire_mode: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> (mode_r == MODE_PRESS_SETTLE || mode_r == MODE_HELD))
    else $error("event fired outside press settle or held");

  // no poll, no change
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(mode_r) && $stable(timer_r)))
    else $error("button state moved without a poll");

  // a press from released loads the short timer
  a_press_load: assert property (@(posedge clk) disable iff (!rst_n)
    (step && pressed && mode_r == MODE_RELEASED) |=>
      (mode_r == MODE_PRESS_SETTLE && timer_r == $past(short_load)))
    else $error("press did not start settling");

  // a release while held never fires and starts release settling
  a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !pressed && mode_r == MODE_HELD) |->
      (!fire ##1 (mode_r == MODE_RELEASE_SETTLE)))
    else $error("release while held handled wrong");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/button_debounce_autorepeat.sv =====
// channel | ports                                   | direction
// in      | in_valid in_stall in_pin_levels in_elapsed_ms | poll word in
// out     | out_valid out_stall out_event_mask      | event word out
// cfg     | cfg_wr_en cfg_index cfg_wdata           | register write, no wait
//
// An accepted poll sits in the input register; its event word becomes valid
// once it has gone through the button machines into the output register.
// A new poll is accepted every cycle while the output side keeps up.
// Reset is synchronous, active low; registers return to 80 and 300 ms.
// A stall on the output holds the event word and backs up into in_stall
// once the input register is also full.
`default_nettype none

module button_debounce_autorepeat #(
  parameter int unsigned NUM_BUTTONS = bda_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned TIMER_WIDTH = bda_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // poll input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bda_pkg::LEVEL_W-1:0]    in_pin_levels,
  input  logic [bda_pkg::ELAPSED_W-1:0]  in_elapsed_ms,
  // event output
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bda_pkg::EVENT_W-1:0]    out_event_mask,
  // register writes
  input  logic                           cfg_wr_en,
  input  logic [bda_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bda_pkg::CFG_W-1:0]      cfg_wdata
);
  import bda_pkg::*;

  localparam int unsigned SAT_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  logic [CFG_W-1:0]       short_time_r, short_time_nxt;
  logic [CFG_W-1:0]       long_time_r, long_time_nxt;
  logic                   s1_valid_r, s1_valid_nxt;
  logic [LEVEL_W-1:0]     s1_levels_r, s1_levels_nxt;
  logic [ELAPSED_W-1:0]   s1_elapsed_r, s1_elapsed_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [EVENT_W-1:0]     out_mask_r, out_mask_nxt;
  logic                   in_accept;
  logic                   out_ready;
  logic                   step;
  logic [SAT_W-1:0]       timer_max;
  logic [SAT_W-1:0]       short_ext;
  logic [SAT_W-1:0]       long_ext;
  logic [TIMER_WIDTH-1:0] short_load;
  logic [TIMER_WIDTH-1:0] long_load;
  logic [NUM_BUTTONS-1:0] fire_v;
  logic [EVENT_W-1:0]     event_mask;

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_accept = in_valid && !in_stall;

  // register file
  always_comb begin
    short_time_nxt = short_time_r;
    long_time_nxt  = long_time_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SHORT_TIME: short_time_nxt = cfg_wdata;
        REG_LONG_TIME:  long_time_nxt  = cfg_wdata;
        default: begin
          short_time_nxt = short_time_r;
        end
      endcase
    end
  end

  // timer load values saturate to the timer width
  assign timer_max  = SAT_W'({TIMER_WIDTH{1'b1}});
  assign short_ext  = SAT_W'(short_time_r);
  assign long_ext   = SAT_W'(long_time_r);
  assign short_load = TIMER_WIDTH'((short_ext > timer_max) ? timer_max : short_ext);
  assign long_load  = TIMER_WIDTH'((long_ext > timer_max) ? timer_max : long_ext);

  // input register
  assign s1_valid_nxt   = in_accept || (s1_valid_r && !step);
  assign s1_levels_nxt  = in_accept ? in_pin_levels : s1_levels_r;
  assign s1_elapsed_nxt = in_accept ? in_elapsed_ms : s1_elapsed_r;

  // one machine per button; buttons past the level field never see a press
  for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
    logic pressed;
    if (gi < FIELD_BUTTONS) begin : g_pin
      assign pressed = !s1_levels_r[gi];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    bda_button #(
      .TIMER_WIDTH (TIMER_WIDTH)
    ) u_button (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .pressed    (pressed),
      .elapsed    (s1_elapsed_r),
      .short_load (short_load),
      .long_load  (long_load),
      .fire       (fire_v[gi])
    );
  end

  // event word, bits beyond the button count read zero
  for (genvar gj = 0; gj < EVENT_W; gj++) begin : g_evt
    if (gj < NUM_BUTTONS) begin : g_used
      assign event_mask[gj] = fire_v[gj];
    end else begin : g_unused
      assign event_mask[gj] = 1'b0;
    end
  end

  // output register
  assign out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  assign out_mask_nxt  = step ? event_mask : out_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_time_r <= SHORT_TIME_RST;
      long_time_r  <= LONG_TIME_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      short_time_r <= short_time_nxt;
      long_time_r  <= long_time_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_levels_r  <= s1_levels_nxt;
    s1_elapsed_r <= s1_elapsed_nxt;
    out_mask_r   <= out_mask_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_mask = out_mask_r;

endmodule

`default_nettype wire

// ===== dv/button_debounce_autorepeat_tb.sv =====
`default_nettype none

module button_debounce_autorepeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bda_pkg::*;

  localparam int unsigned NUM_BTN     = NUM_BUTTONS_DEF;
  localparam int unsigned TIMER_W     = TIMER_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned NUM_PHASES  = 9;
  localparam int unsigned PHASE_POLLS = 170;

  // register settings per random phase, extremes and a zero setting included
  localparam logic [CFG_W-1:0] PHASE_SHORT [NUM_PHASES] =
    '{16'd3, 16'd1, 16'd0, 16'hFFFF, 16'd12, 16'd1, 16'hFFFF, 16'd0, 16'd80};
  localparam logic [CFG_W-1:0] PHASE_LONG [NUM_PHASES] =
    '{16'd5, 16'd1, 16'd0, 16'hFFFF, 16'd40, 16'hFFFF, 16'd1, 16'd7, 16'd300};

  typedef struct packed {
    logic [LEVEL_W-1:0]   levels;
    logic [ELAPSED_W-1:0] elapsed;
  } poll_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [LEVEL_W-1:0]   in_pin_levels = '1;
  logic [ELAPSED_W-1:0] in_elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [EVENT_W-1:0]   out_event_mask;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SHORT_TIME;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  button_debounce_autorepeat i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pin_levels  (in_pin_levels),
    .in_elapsed_ms  (in_elapsed_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_mask (out_event_mask),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // polls waiting to be sent and event masks waiting to come back
  poll_t              poll_q [$];
  logic [EVENT_W-1:0] event_q [$];
  int unsigned        err_count = 0;

  // debounce state and register copies as the block should hold them
  mode_t              btn_mode  [NUM_BTN];
  logic [TIMER_W-1:0] btn_timer [NUM_BTN];
  logic [CFG_W-1:0]   short_ms = SHORT_TIME_RST;
  logic [CFG_W-1:0]   long_ms  = LONG_TIME_RST;

  // intended button levels that the random polls follow
  logic [LEVEL_W-1:0] held_levels = '1;

  // one poll through all button machines, returns the event mask
  function automatic logic [EVENT_W-1:0] debounce_poll(input logic [LEVEL_W-1:0] levels,
                                                       input logic [ELAPSED_W-1:0] elapsed);
    logic [EVENT_W-1:0] mask;
    logic               pressed;
    logic               expired;
    mask = '0;
    for (int b = 0; b < NUM_BTN; b++) begin
      pressed = !levels[b];
      expired = elapsed >= btn_timer[b];
      case (btn_mode[b])
        MODE_RELEASED: begin
          if (pressed) begin
            btn_mode[b]  = MODE_PRESS_SETTLE;
            btn_timer[b] = short_ms;
          end
        end
        // level is not looked at while a press settles
        MODE_PRESS_SETTLE: begin
          if (expired) begin
            mask[b]      = 1'b1;
            btn_mode[b]  = MODE_HELD;
            btn_timer[b] = long_ms;
          end else begin
            btn_timer[b] = btn_timer[b] - elapsed;
          end
        end
        // release wins over a repeat in the same poll
        MODE_HELD: begin
          if (!pressed) begin
            btn_mode[b]  = MODE_RELEASE_SETTLE;
            btn_timer[b] = short_ms;
          end else if (expired) begin
            mask[b]      = 1'b1;
            btn_timer[b] = long_ms;
          end else begin
            btn_timer[b] = btn_timer[b] - elapsed;
          end
        end
        // timer is left as is on the way back to released
        default: begin
          if (expired) btn_mode[b] = MODE_RELEASED;
          else btn_timer[b] = btn_timer[b] - elapsed;
        end
      endcase
    end
    return mask;
  endfunction

  task automatic queue_poll(input logic [LEVEL_W-1:0] levels,
                            input logic [ELAPSED_W-1:0] elapsed);
    poll_q.push_back('{levels: levels, elapsed: elapsed});
  endtask

  // mostly steady levels with rare flips and glitches, elapsed scaled to the timers
  task automatic queue_random_polls(input int unsigned count);
    logic [LEVEL_W-1:0]   levels;
    logic [ELAPSED_W-1:0] elapsed;
    int unsigned          pick;
    repeat (count) begin
      for (int b = 0; b < NUM_BTN; b++)
        if ($urandom_range(0, 11) == 0) held_levels[b] = !held_levels[b];
      levels = held_levels;
      if ($urandom_range(0, 19) == 0) levels = LEVEL_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 12) elapsed = '0;
      else if (pick < 18) elapsed = ELAPSED_W'($urandom);
      else if (pick < 22) elapsed = '1;
      else if (pick < 60) elapsed = ELAPSED_W'($urandom_range(0, short_ms));
      else elapsed = ELAPSED_W'($urandom_range(0, long_ms));
      queue_poll(levels, elapsed);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_SHORT_TIME) short_ms = data;
    else long_ms = data;
  endtask

  // hold off until every sent poll has its event word back, sampled mid-cycle
  task automatic wait_drained();
    while (poll_q.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    forever #4 clk = ~clk;
  end

  // sequence: reset, directed polls, then random phases each with new registers
  initial begin
    foreach (btn_mode[b]) begin
      btn_mode[b]  = MODE_RELEASED;
      btn_timer[b] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // press, settle boundary, first event, repeat boundary
    queue_poll(5'b11111, 16'd0);
    queue_poll(5'b00000, 16'd0);
    queue_poll(5'b00000, 16'd79);
    queue_poll(5'b00000, 16'd0);
    queue_poll(5'b00000, 16'd1);
    queue_poll(5'b00000, 16'd299);
    queue_poll(5'b00000, 16'd1);
    queue_poll(5'b00000, 16'd300);
    // release of some buttons with a huge elapsed time while others repeat
    queue_poll(5'b01010, 16'hFFFF);
    // release settling ignores a press, then returns to released
    queue_poll(5'b00000, 16'd40);
    queue_poll(5'b00000, 16'd40);
    queue_poll(5'b00000, 16'd0);
    // press settling ignores a release
    queue_poll(5'b11111, 16'd80);
    queue_poll(5'b11111, 16'hFFFF);
    queue_poll(5'b11110, 16'd0);
    queue_poll(5'b11111, 16'h8000);
    queue_poll(5'b11111, 16'h5555);
    queue_poll(5'b10101, 16'hAAAA);
    queue_poll(5'b00000, 16'hFFFF);
    queue_poll(5'b00000, 16'hFFFF);
    queue_poll(5'b11111, 16'd0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_SHORT_TIME, PHASE_SHORT[p]);
      write_reg(REG_LONG_TIME, PHASE_LONG[p]);
      queue_random_polls(PHASE_POLLS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // poll sender: bursts of random length with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left   = 0;
  poll_t       next_poll;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        event_q.push_back(debounce_poll(in_pin_levels, in_elapsed_ms));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || poll_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_poll = poll_q.pop_front();
          in_valid      <= 1'b1;
          in_pin_levels <= next_poll.levels;
          in_elapsed_ms <= next_poll.elapsed;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(15, 30);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end
      end
    end
  end

  // event word checker and output stall pattern
  int unsigned        stall_hold = 0;
  int unsigned        stall_pct  = 0;
  logic [EVENT_W-1:0] want_mask;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (event_q.size() == 0) begin
          $error("event word with no poll pending: event_mask %0h", out_event_mask);
          err_count++;
        end else begin
          want_mask = event_q.pop_front();
          if (out_event_mask !== want_mask) begin
            $error("event_mask mismatch: expected %0h, actual %0h", want_mask, out_event_mask);
            err_count++;
          end
        end
      end
      // stall density changes every stretch, including stretches with none
      if (stall_hold == 0) begin
        stall_hold = $urandom_range(40, 160);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 15;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        stall_hold--;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // run limit
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/bda_pkg.sv
rtl/core/bda_button.sv
rtl/core/button_debounce_autorepeat.sv
dv/button_debounce_autorepeat_tb.sv
